// File: rtl/lpc_pkg.sv
// lpc_pkg: shared types, register indexes and the gamma 2.8 table for the
// led pixel color pipeline. No dependencies.
package lpc_pkg;

  typedef logic [23:0] pixel_t;
  typedef logic [7:0]  chan_t;

  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECOLOR_EN    = 3'd0,
    REG_RECOLOR_COLOR = 3'd1,
    REG_RAINBOW_EN    = 3'd2,
    REG_RAINBOW_HUE   = 3'd3,
    REG_GAMMA_EN      = 3'd4
  } lpc_reg_e;

  localparam pixel_t PIX_BLACK = 24'h000000;
  localparam pixel_t PIX_WHITE = 24'hFFFFFF;
  localparam chan_t  CHAN_MAX  = 8'hFF;

  // hue wheel: regions of 43 hue steps, remainder scaled by 6
  localparam chan_t HUE_SECTOR = 8'd43;
  localparam chan_t HUE_SCALE  = 8'd6;

  // gamma 2.8 lookup, indexed by channel value
  localparam chan_t GAMMA_LUT [0:255] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
    8'd2, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
    8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5,
    8'd5, 8'd6, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7,
    8'd7, 8'd8, 8'd8, 8'd8, 8'd9, 8'd9, 8'd9, 8'd10,
    8'd10, 8'd10, 8'd11, 8'd11, 8'd11, 8'd12, 8'd12, 8'd13,
    8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15, 8'd16, 8'd16,
    8'd17, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19, 8'd20, 8'd20,
    8'd21, 8'd21, 8'd22, 8'd22, 8'd23, 8'd24, 8'd24, 8'd25,
    8'd25, 8'd26, 8'd27, 8'd27, 8'd28, 8'd29, 8'd29, 8'd30,
    8'd31, 8'd32, 8'd32, 8'd33, 8'd34, 8'd35, 8'd35, 8'd36,
    8'd37, 8'd38, 8'd39, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43,
    8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd50,
    8'd51, 8'd52, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd59,
    8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd66, 8'd67, 8'd68,
    8'd69, 8'd70, 8'd72, 8'd73, 8'd74, 8'd75, 8'd77, 8'd78,
    8'd79, 8'd81, 8'd82, 8'd83, 8'd85, 8'd86, 8'd87, 8'd89,
    8'd90, 8'd92, 8'd93, 8'd95, 8'd96, 8'd98, 8'd99, 8'd101,
    8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
    8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
    8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
    8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
    8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
    8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
    8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
    8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
    8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
  };

endpackage

// File: rtl/lpc_pix_in_if.sv
// lpc_pix_in_if: valid/ready channel carrying one input pixel item.
// Depends on lpc_pkg.
interface lpc_pix_in_if;
  logic            valid;
  logic            ready;
  lpc_pkg::pixel_t pixel_in;
  logic            frame_end_in;

  modport source (output valid, output pixel_in, output frame_end_in, input ready);
  modport sink   (input valid, input pixel_in, input frame_end_in, output ready);
endinterface

// File: rtl/lpc_pix_out_if.sv
// lpc_pix_out_if: valid/ready channel carrying one result pixel item.
// Depends on lpc_pkg.
interface lpc_pix_out_if;
  logic            valid;
  logic            ready;
  lpc_pkg::pixel_t pixel_out;
  logic            frame_end_out;

  modport source (output valid, output pixel_out, output frame_end_out, input ready);
  modport sink   (input valid, input pixel_out, input frame_end_out, output ready);
endinterface

// File: rtl/lpc_cfg_if.sv
// lpc_cfg_if: configuration write channel, register index and write data.
// Depends on lpc_pkg.
interface lpc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lpc_pkg::CFG_IDX_W-1:0]     index;
  logic [23:0]                       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/led_pixel_color_pipeline_unit.sv
// An accepted item passes through three register stages in order: input,
// recolor/rainbow and gamma. Throughput: one item per cycle while the output
// is ready; each stage advances when the next one is free.
// Reset (rst_ni low, asynchronous) empties all stages and clears every
// configuration register to zero; configuration writes are always accepted.
// Top level of the led pixel color pipeline. Depends on lpc_pkg and the
// lpc_pix_in_if, lpc_pix_out_if and lpc_cfg_if interfaces.
module led_pixel_color_pipeline_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lpc_cfg_if.sink              cfg_i,
  lpc_pix_in_if.sink           in_i,
  lpc_pix_out_if.source        out_o
);
  import lpc_pkg::*;

  // configuration registers
  logic   recolor_en_q;
  pixel_t recolor_color_q;
  logic   rainbow_en_q;
  chan_t  rainbow_hue_q;
  logic   gamma_en_q;

  // pipeline stages
  logic   a_vld_q, b_vld_q, o_vld_q;
  pixel_t a_pix_q, b_pix_q, o_pix_q;
  logic   a_fe_q, b_fe_q, o_fe_q;
  logic   a_ready, b_ready, o_ready;
  pixel_t recolor_pix, b_pix_d, o_pix_d;
  pixel_t wheel_pix;

  // hue wheel color of a hue position
  function automatic pixel_t wheel_color(input chan_t hue);
    logic [2:0]  region;
    chan_t       base;
    chan_t       rem;
    logic [15:0] prod;
    chan_t       t;
    chan_t       q;
    pixel_t      res;
    if (hue >= 8'(5 * HUE_SECTOR)) begin
      region = 3'd5;
      base   = 8'(5 * HUE_SECTOR);
    end else if (hue >= 8'(4 * HUE_SECTOR)) begin
      region = 3'd4;
      base   = 8'(4 * HUE_SECTOR);
    end else if (hue >= 8'(3 * HUE_SECTOR)) begin
      region = 3'd3;
      base   = 8'(3 * HUE_SECTOR);
    end else if (hue >= 8'(2 * HUE_SECTOR)) begin
      region = 3'd2;
      base   = 8'(2 * HUE_SECTOR);
    end else if (hue >= HUE_SECTOR) begin
      region = 3'd1;
      base   = HUE_SECTOR;
    end else begin
      region = 3'd0;
      base   = 8'd0;
    end
    rem  = 8'((hue - base) * HUE_SCALE);
    // 255 * rem, then keep the upper byte
    prod = {rem, 8'd0} - {8'd0, rem};
    t    = prod[15:8];
    q    = CHAN_MAX - t;
    unique case (region)
      3'd0:    res = {CHAN_MAX, t, 8'd0};
      3'd1:    res = {q, CHAN_MAX, 8'd0};
      3'd2:    res = {8'd0, CHAN_MAX, t};
      3'd3:    res = {8'd0, q, CHAN_MAX};
      3'd4:    res = {t, 8'd0, CHAN_MAX};
      default: res = {CHAN_MAX, 8'd0, q};
    endcase
    return res;
  endfunction

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recolor_en_q    <= 1'b0;
      recolor_color_q <= PIX_BLACK;
      rainbow_en_q    <= 1'b0;
      rainbow_hue_q   <= 8'd0;
      gamma_en_q      <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_RECOLOR_EN:    recolor_en_q    <= cfg_i.data[0];
        REG_RECOLOR_COLOR: recolor_color_q <= cfg_i.data;
        REG_RAINBOW_EN:    rainbow_en_q    <= cfg_i.data[0];
        REG_RAINBOW_HUE:   rainbow_hue_q   <= cfg_i.data[7:0];
        REG_GAMMA_EN:      gamma_en_q      <= cfg_i.data[0];
        default:           ;
      endcase
    end
  end

  // stage flow control, each stage moves when the one after it can take it
  assign o_ready    = !o_vld_q || out_o.ready;
  assign b_ready    = !b_vld_q || o_ready;
  assign a_ready    = !a_vld_q || b_ready;
  assign in_i.ready = a_ready;

  // recolor, then rainbow on pure white
  assign wheel_pix = wheel_color(rainbow_hue_q);

  always_comb begin
    recolor_pix = a_pix_q;
    if (recolor_en_q && (a_pix_q != PIX_BLACK)) begin
      recolor_pix = recolor_color_q;
    end
    b_pix_d = recolor_pix;
    if (rainbow_en_q && (recolor_pix == PIX_WHITE)) begin
      b_pix_d = wheel_pix;
    end
  end

  // gamma lookup per channel
  always_comb begin
    o_pix_d = b_pix_q;
    if (gamma_en_q) begin
      o_pix_d = {GAMMA_LUT[b_pix_q[23:16]], GAMMA_LUT[b_pix_q[15:8]],
                 GAMMA_LUT[b_pix_q[7:0]]};
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_vld_q <= in_i.valid;
      end
      if (b_ready) begin
        b_vld_q <= a_vld_q;
      end
      if (o_ready) begin
        o_vld_q <= b_vld_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (in_i.valid && a_ready) begin
      a_pix_q <= in_i.pixel_in;
      a_fe_q  <= in_i.frame_end_in;
    end
    if (a_vld_q && b_ready) begin
      b_pix_q <= b_pix_d;
      b_fe_q  <= a_fe_q;
    end
    if (b_vld_q && o_ready) begin
      o_pix_q <= o_pix_d;
      o_fe_q  <= b_fe_q;
    end
  end

  assign out_o.valid         = o_vld_q;
  assign out_o.pixel_out     = o_pix_q;
  assign out_o.frame_end_out = o_fe_q;

  // checks
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (a_vld_q && b_vld_q && o_vld_q))
    else $error("input stalled with an empty stage");

  a_fe_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_vld_q && b_ready) |=> (b_vld_q && (b_fe_q == $past(a_fe_q))))
    else $error("frame end lost between stages");

  a_plain_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_vld_q && b_ready && !recolor_en_q && !rainbow_en_q)
      |=> (b_pix_q == $past(a_pix_q)))
    else $error("pixel changed with recolor and rainbow off");

  a_plain_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && o_ready && !gamma_en_q) |=> (o_vld_q && (o_pix_q == $past(b_pix_q))))
    else $error("pixel changed with gamma off");

endmodule
